// ----- sv/nps_pkg.sv -----
// Shared constants and the arctangent table for the nonlinear plant step block.
// Used by the plant step core, the top level and the port checker.
// No dependencies.
package nps_pkg;

  // Default sample width; fraction bits are always the width minus four.
  localparam int DATA_WIDTH_DEF = 16;
  localparam int INT_BITS       = 4;

  // Angle and rotation datapath, Q30 angles.
  localparam int ANG_BITS     = 30;
  localparam int CORDIC_STEPS = 31;
  localparam int STEP_W       = 5;
  localparam int ZW           = 38;
  localparam int XW           = 34;

  localparam logic signed [ZW-1:0] PI_Q30      = 38'sd3373259426;
  localparam logic signed [ZW-1:0] HALF_PI_Q30 = 38'sd1686629713;
  localparam logic signed [ZW-1:0] TWO_PI_Q30  = 38'sd6746518852;
  localparam logic signed [XW-1:0] GAIN_Q30    = 34'sd652032874;
  localparam logic signed [XW-1:0] POINT8_Q30  = 34'sd858993459;

  // Arctangent of 2^-i in Q30.
  function automatic logic [ZW-1:0] atan_q30(input logic [STEP_W-1:0] i);
    logic [31:0] v;
    case (i)
      5'd0:  v = 32'h3243F6A8;
      5'd1:  v = 32'h1DAC6705;
      5'd2:  v = 32'h0FADBAFC;
      5'd3:  v = 32'h07F56EA6;
      5'd4:  v = 32'h03FEAB76;
      5'd5:  v = 32'h01FFD55B;
      5'd6:  v = 32'h00FFFAAA;
      5'd7:  v = 32'h007FFF55;
      5'd8:  v = 32'h003FFFEA;
      5'd9:  v = 32'h001FFFFD;
      5'd10: v = 32'h000FFFFF;
      5'd11: v = 32'h0007FFFF;
      5'd12: v = 32'h0003FFFF;
      5'd13: v = 32'h0001FFFF;
      5'd14: v = 32'h0000FFFF;
      5'd15: v = 32'h00007FFF;
      5'd16: v = 32'h00003FFF;
      5'd17: v = 32'h00001FFF;
      5'd18: v = 32'h00000FFF;
      5'd19: v = 32'h000007FF;
      5'd20: v = 32'h000003FF;
      5'd21: v = 32'h000001FF;
      5'd22: v = 32'h000000FF;
      5'd23: v = 32'h0000007F;
      5'd24: v = 32'h0000003F;
      5'd25: v = 32'h0000001F;
      5'd26: v = 32'h0000000F;
      5'd27: v = 32'h00000008;
      5'd28: v = 32'h00000004;
      5'd29: v = 32'h00000002;
      5'd30: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return ZW'(v);
  endfunction

endpackage

// ----- sv/nps_core.sv -----
// Sequencer and shared datapath that computes one plant output y(k+1).
// Holds one multiplier, a restoring divider step and a rotation step.
// Depends on nps_pkg.
module nps_core #(
  parameter int DW = nps_pkg::DATA_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic                 take,
  input  logic signed [DW-1:0] a,
  input  logic signed [DW-1:0] b,
  input  logic signed [DW-1:0] c,
  input  logic signed [DW-1:0] u,
  output logic                 done,
  output logic signed [DW-1:0] result
);
  import nps_pkg::*;

  localparam int F   = DW - INT_BITS;
  localparam int NW  = 2 * DW;
  localparam int DVW = DW + 5;
  localparam int RW  = DW + 6;
  localparam int PW  = XW + DW;
  localparam int SW  = DW + 4;
  localparam int CW  = $clog2(NW);
  localparam int SH  = ANG_BITS - F;
  localparam longint HI_L = (64'sd1 <<< (DW - 1)) - 64'sd1;
  localparam logic signed [SW-1:0] SAT_HI = SW'(HI_L);
  localparam logic signed [SW-1:0] SAT_LO = -SAT_HI - SW'(1);

  typedef enum logic [3:0] {
    S_IDLE, S_MAB, S_MAA, S_MBB, S_DEN, S_DIVL, S_DIV, S_RATIO,
    S_RED, S_FOLD, S_ROT, S_POST, S_MC, S_MU, S_ACC, S_DONE
  } state_t;

  state_t                 state;
  logic signed [PW-1:0]   prod;
  logic                   neg;
  logic        [NW-1:0]   mag;
  logic        [NW:0]     den;
  logic        [NW-1:0]   quo;
  logic        [RW-1:0]   rem;
  logic        [CW-1:0]   cnt;
  logic signed [SW-1:0]   acc;
  logic signed [ZW-1:0]   z;
  logic signed [XW-1:0]   x;
  logic signed [XW-1:0]   y;
  logic signed [XW-1:0]   cs;
  logic        [STEP_W-1:0] step;
  logic                   flip;
  logic                   second;

  logic signed [XW-1:0]   mul_x;
  logic signed [DW-1:0]   mul_y;
  logic signed [PW-1:0]   mul_p;
  logic signed [NW-1:0]   ab;
  logic        [DVW-1:0]  dvs;
  logic        [RW-1:0]   trial;
  logic        [DW+2:0]   q3;
  logic        [SW-1:0]   half_q;
  logic signed [XW-1:0]   xs;
  logic signed [XW-1:0]   ys;
  logic signed [XW-1:0]   xf;
  logic signed [XW-1:0]   yf;
  logic signed [XW-1:0]   ysh;
  logic signed [DW:0]     ang_sum;
  logic signed [DW:0]     ang_diff;
  logic signed [SW-1:0]   prod_term;

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_x = '0;
    mul_y = '0;
    unique case (state)
      S_MAB: begin mul_x = XW'(a); mul_y = b; end
      S_MAA: begin mul_x = XW'(a); mul_y = a; end
      S_MBB: begin mul_x = XW'(b); mul_y = b; end
      S_MC:  begin mul_x = POINT8_Q30; mul_y = c; end
      S_MU:  begin mul_x = cs; mul_y = u; end
      default: begin mul_x = '0; mul_y = '0; end
    endcase
  end

  assign mul_p = PW'(mul_x) * PW'(mul_y);

  // Divider step, ratio scaling and rotation step.
  always_comb begin
    ab        = prod[NW-1:0];
    dvs       = den[NW:F];
    trial     = {rem[RW-2:0], quo[NW-1]};
    q3        = {2'b00, quo[DW:0]} + {1'b0, quo[DW:0], 1'b0};
    half_q    = SW'(q3[DW+2:1]);
    xs        = x >>> step;
    ys        = y >>> step;
    xf        = flip ? -x : x;
    yf        = flip ? -y : y;
    ysh       = yf >>> SH;
    ang_sum   = (DW+1)'(a) + (DW+1)'(b);
    ang_diff  = (DW+1)'(a) - (DW+1)'(c);
    prod_term = SW'(prod >>> ANG_BITS);
  end

  // Sequencer with its working registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            den   <= (NW+1)'(1) << (2 * F);
            state <= S_MAB;
          end
        end
        S_MAB: begin
          prod  <= mul_p;
          state <= S_MAA;
        end
        S_MAA: begin
          neg   <= ab[NW-1];
          mag   <= ab[NW-1] ? NW'(-ab) : NW'(ab);
          prod  <= mul_p;
          state <= S_MBB;
        end
        S_MBB: begin
          den   <= den + (NW+1)'(prod[NW-1:0]);
          prod  <= mul_p;
          state <= S_DEN;
        end
        S_DEN: begin
          den   <= den + (NW+1)'(prod[NW-1:0]);
          state <= S_DIVL;
        end
        S_DIVL: begin
          quo   <= {mag[NW-1:F], {F{1'b0}}};
          rem   <= '0;
          cnt   <= CW'(NW - 1);
          state <= S_DIV;
        end
        S_DIV: begin
          // One quotient bit per cycle.
          if (trial >= {1'b0, dvs}) begin
            rem <= trial - {1'b0, dvs};
            quo <= {quo[NW-2:0], 1'b1};
          end else begin
            rem <= trial;
            quo <= {quo[NW-2:0], 1'b0};
          end
          cnt <= cnt - CW'(1);
          if (cnt == '0) begin
            state <= S_RATIO;
          end
        end
        S_RATIO: begin
          acc    <= neg ? -$signed(half_q) : $signed(half_q);
          z      <= ZW'(ang_sum) <<< SH;
          second <= 1'b0;
          state  <= S_RED;
        end
        S_RED: begin
          // Bring the angle into the range from -pi to pi.
          if (z > PI_Q30) begin
            z <= z - TWO_PI_Q30;
          end else if (z < -PI_Q30) begin
            z <= z + TWO_PI_Q30;
          end else begin
            state <= S_FOLD;
          end
        end
        S_FOLD: begin
          if (z > HALF_PI_Q30) begin
            z    <= z - PI_Q30;
            flip <= 1'b1;
          end else if (z < -HALF_PI_Q30) begin
            z    <= z + PI_Q30;
            flip <= 1'b1;
          end else begin
            flip <= 1'b0;
          end
          x     <= GAIN_Q30;
          y     <= '0;
          step  <= '0;
          state <= S_ROT;
        end
        S_ROT: begin
          if (!z[ZW-1]) begin
            x <= x - ys;
            y <= y + xs;
            z <= z - $signed(atan_q30(step));
          end else begin
            x <= x + ys;
            y <= y - xs;
            z <= z + $signed(atan_q30(step));
          end
          step <= step + STEP_W'(1);
          if (step == STEP_W'(CORDIC_STEPS - 1)) begin
            state <= S_POST;
          end
        end
        S_POST: begin
          if (!second) begin
            acc    <= acc + SW'(ysh);
            z      <= ZW'(ang_diff) <<< SH;
            second <= 1'b1;
            state  <= S_RED;
          end else begin
            cs    <= xf;
            state <= S_MC;
          end
        end
        S_MC: begin
          prod  <= mul_p;
          state <= S_MU;
        end
        S_MU: begin
          acc   <= acc + prod_term;
          prod  <= mul_p;
          state <= S_ACC;
        end
        S_ACC: begin
          // Final term and clamp to the sample range.
          if (acc + prod_term > SAT_HI) begin
            result <= DW'(SAT_HI);
          end else if (acc + prod_term < SAT_LO) begin
            result <= DW'(SAT_LO);
          end else begin
            result <= DW'(acc + prod_term);
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (take) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign done = (state == S_DONE);

endmodule

// ----- sv/nonlinear_plant_step.sv -----
// Top level of the nonlinear plant step block: handshake, state and output item.
// Instantiates nps_core; depends on nps_pkg.
//
// Usage:
// Each input item carries one control sample u(k) and a start flag. The
// block returns one result item with y(k+1) and the regressor row
// y(k), y(k-1), u(k-1) used for it. A start flag reloads y(k) from the
// initial output register and clears the older terms before the step.
// Both channels use valid and ready. The block takes one item at a time:
// after an accept, in_ready stays low until the result has been written
// to the output register. The busy time is set by the shared divider, one
// quotient bit per cycle, the two 31-step rotation passes on one rotator,
// and the angle reduction before each pass. A result waiting in the output
// register does not block the next accept; if the receiver still stalls
// when the next result is ready, the core holds it and the block stays
// busy until out_ready. The user must write the initial output register
// with cfg_we and cfg_wdata only while idle; the block does not enforce it.
// Synchronous reset sets y(0) to 0.3, clears the older terms and drops
// out_valid.
module nonlinear_plant_step #(
  parameter int DATA_WIDTH = nps_pkg::DATA_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [DATA_WIDTH-1:0] control_sample,
  input  logic                         start_of_sequence,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [DATA_WIDTH-1:0] next_output,
  output logic signed [DATA_WIDTH-1:0] regressor_current,
  output logic signed [DATA_WIDTH-1:0] regressor_previous,
  output logic signed [DATA_WIDTH-1:0] regressor_control,
  input  logic                         cfg_we,
  input  logic signed [DATA_WIDTH-1:0] cfg_wdata
);
  import nps_pkg::*;

  localparam int F = DATA_WIDTH - INT_BITS;
  localparam longint INIT_L = ((64'sd3 <<< F) + 64'sd5) / 64'sd10;
  localparam logic signed [DATA_WIDTH-1:0] INIT_OUT = DATA_WIDTH'(INIT_L);

  typedef enum logic {T_IDLE, T_BUSY} state_t;

  state_t                        state;
  logic signed [DATA_WIDTH-1:0]  init_out;
  logic signed [DATA_WIDTH-1:0]  out_now;
  logic signed [DATA_WIDTH-1:0]  out_before;
  logic signed [DATA_WIDTH-1:0]  ctl_before;
  logic signed [DATA_WIDTH-1:0]  ctl_now;
  logic                          start_pulse;
  logic                          accept;
  logic                          take;
  logic                          finish;
  logic                          core_done;
  logic signed [DATA_WIDTH-1:0]  core_result;

  assign in_ready = (state == T_IDLE);
  assign accept   = in_valid && in_ready;
  assign take     = !out_valid || out_ready;

  // The core result moves into the output register this cycle.
  assign finish   = (state == T_BUSY) && core_done && take;

  // Plant step core.
  nps_core #(.DW(DATA_WIDTH)) u_core (
    .clk    (clk),
    .rst    (rst),
    .start  (start_pulse),
    .take   (take),
    .a      (out_now),
    .b      (out_before),
    .c      (ctl_before),
    .u      (ctl_now),
    .done   (core_done),
    .result (core_result)
  );

  // Handshake, plant state and output item.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= T_IDLE;
      out_valid   <= 1'b0;
      start_pulse <= 1'b0;
      init_out    <= INIT_OUT;
      out_now     <= INIT_OUT;
      out_before  <= '0;
      ctl_before  <= '0;
    end else begin
      start_pulse <= accept;
      if (cfg_we) begin
        init_out <= cfg_wdata;
      end
      if (finish) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        T_IDLE: begin
          if (accept) begin
            ctl_now <= control_sample;
            if (start_of_sequence) begin
              out_now    <= init_out;
              out_before <= '0;
              ctl_before <= '0;
            end
            state <= T_BUSY;
          end
        end
        T_BUSY: begin
          if (finish) begin
            next_output        <= core_result;
            regressor_current  <= out_now;
            regressor_previous <= out_before;
            regressor_control  <= ctl_before;
            out_before         <= out_now;
            out_now            <= core_result;
            ctl_before         <= ctl_now;
            state              <= T_IDLE;
          end
        end
        default: state <= T_IDLE;
      endcase
    end
  end

endmodule

// ----- sv/nps_checker.sv -----
// Port checker for the nonlinear plant step block, bound to the top level.
// Depends on nps_pkg and on the port list of nonlinear_plant_step.
module nps_checker #(
  parameter int DATA_WIDTH = nps_pkg::DATA_WIDTH_DEF
) (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic signed [DATA_WIDTH-1:0] control_sample,
  input logic                         start_of_sequence,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic signed [DATA_WIDTH-1:0] next_output,
  input logic signed [DATA_WIDTH-1:0] regressor_current,
  input logic signed [DATA_WIDTH-1:0] regressor_previous,
  input logic signed [DATA_WIDTH-1:0] regressor_control,
  input logic                         cfg_we,
  input logic signed [DATA_WIDTH-1:0] cfg_wdata
);
  import nps_pkg::*;

  // A stalled result item keeps out_valid, next_output and regressor_current.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(next_output)
      && $stable(regressor_current))
    else $error("result item changed while stalled");

  // The block works on one item at a time.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("ready right after an accepted item");

  // Reset leaves the block idle with no result item.
  a_reset: assert property (@(posedge clk)
    rst |=> in_ready && !out_valid)
    else $error("block not idle after reset");

  // A new result item appears only while the block is finishing work.
  a_new_result: assert property (@(posedge clk) disable iff (rst)
    !out_valid ##1 out_valid |-> in_ready && !$past(in_ready))
    else $error("result item without a pending item");

endmodule

bind nonlinear_plant_step nps_checker #(.DATA_WIDTH(DATA_WIDTH)) u_nps_checker (.*);
